>>> hdl/mandelbrot_membership_top_macros.svh
// Assertion macros for the Mandelbrot membership block.
`ifndef MANDELBROT_MEMBERSHIP_TOP_MACROS_SVH
`define MANDELBROT_MEMBERSHIP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mbm assertion failed");
`define MBM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mbm assertion failed");
`else
`define MBM_ASSERT(lbl, clk, rst_n, prop)
`define MBM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/mbm_pkg.sv
// Shared types, constants and helpers for the Mandelbrot membership block.
package mbm_pkg;

  localparam int MaxColumns = 4096;
  localparam int MaxRows    = 4096;
  localparam int SatW       = 48;

  localparam logic [2:0] RegXStart   = 3'd0;
  localparam logic [2:0] RegXStep    = 3'd1;
  localparam logic [2:0] RegYStart   = 3'd2;
  localparam logic [2:0] RegYStep    = 3'd3;
  localparam logic [2:0] RegBailout  = 3'd4;
  localparam logic [2:0] RegMaxIter  = 3'd5;

  typedef enum logic [3:0] {
    OpIdle,
    OpLoad,
    OpCx,
    OpCy,
    OpCi,
    OpAa,
    OpBb,
    OpAb,
    OpUpd
  } mbm_op_e;

  typedef struct packed {
    logic signed [31:0] x_start;
    logic signed [31:0] x_step;
    logic signed [31:0] y_start;
    logic signed [31:0] y_step;
    logic [31:0]        bailout;
    logic [15:0]        max_iter;
  } cfg_t;

  typedef struct packed {
    mbm_op_e     op;
    logic [11:0] column;
    logic [11:0] row;
  } ctrl_t;

  typedef struct packed {
    logic escape;
    logic last;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [SatW-1:0] v);
    if (v > SatW'(64'sh0000_0000_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -SatW'(64'sh0000_0000_8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> hdl/mbm_core.sv
// Fixed-point datapath with one shared 32x32 multiplier for the pixel coordinates and the orbit iteration.
module mbm_core import mbm_pkg::*; (
  input  logic    clk_i,
  input  ctrl_t   ctrl_i,
  input  cfg_t    cfg_i,
  output status_t status_o
);

  logic [11:0]        col_q, row_q;
  logic signed [31:0] a_q, b_q, cre_q, cim_q;
  logic signed [63:0] p_q, diff_q;
  logic [63:0]        aa_q;
  logic [15:0]        iter_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [63:0]        norm_sum;
  logic signed [SatW-1:0] cre_sum, cim_sum, a_sum, b_sum;

  always_comb begin
    case (ctrl_i.op)
      OpCx: begin
        mul_a = $signed({20'd0, col_q});
        mul_b = cfg_i.x_step;
      end
      OpCy: begin
        mul_a = $signed({20'd0, row_q});
        mul_b = cfg_i.y_step;
      end
      OpAa: begin
        mul_a = a_q;
        mul_b = a_q;
      end
      OpBb: begin
        mul_a = b_q;
        mul_b = b_q;
      end
      default: begin
        mul_a = a_q;
        mul_b = b_q;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign norm_sum = aa_q + p_q;
  assign cre_sum  = SatW'(cfg_i.x_start) + $signed(p_q[SatW-1:0]);
  assign cim_sum  = SatW'(cfg_i.y_start) + $signed(p_q[SatW-1:0]);
  assign a_sum    = SatW'($signed(diff_q[63:28])) + SatW'(cre_q);
  assign b_sum    = SatW'($signed(p_q[63:27])) + SatW'(cim_q);

  assign status_o.escape = (|norm_sum[63:62]) || (norm_sum[61:30] >= cfg_i.bailout);
  assign status_o.last   = (iter_q == cfg_i.max_iter);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OpLoad: begin
        col_q  <= (32'(ctrl_i.column) >= MaxColumns) ? 12'(MaxColumns - 1) : ctrl_i.column;
        row_q  <= (32'(ctrl_i.row) >= MaxRows) ? 12'(MaxRows - 1) : ctrl_i.row;
        a_q    <= '0;
        b_q    <= '0;
        iter_q <= '0;
      end
      OpCx: begin
        p_q <= prod;
      end
      OpCy: begin
        cre_q <= sat32(cre_sum);
        p_q   <= prod;
      end
      OpCi: begin
        cim_q <= sat32(cim_sum);
      end
      OpAa: begin
        p_q <= prod;
      end
      OpBb: begin
        aa_q <= p_q;
        p_q  <= prod;
      end
      OpAb: begin
        diff_q <= $signed(aa_q) - p_q;
        p_q    <= prod;
      end
      OpUpd: begin
        a_q    <= sat32(a_sum);
        b_q    <= sat32(b_sum);
        iter_q <= iter_q + 16'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/mandelbrot_membership_top.sv
// Mandelbrot membership test: config registers, sequencer and output register.
//
// Input channel (in_valid_i/in_ready_o) transfers a pixel column and row.
// Output channel (out_valid_o/out_ready_i) transfers one bit per pixel:
// 1 when the orbit stayed below the bailout, 0 when it escaped.
// The block works on one pixel at a time and drops in_ready_o meanwhile.
// Every orbit step runs three products (a*a, b*b, a*b) through one shared
// 32x32 multiplier in states SAa, SBb and SAb, then updates in SUpd.
// A pixel passes SCx, SCy and SCi to form c, then runs orbit steps until it
// escapes or has done as many updates as the iteration limit (default 255),
// and waits in SDone until the output register is free.
// Configuration writes (cfg_we_i) take effect at once; write them only
// while no pixel is in flight. Indexes 6 and 7 are ignored.
// Reset loads the default view, bailout and iteration limit and empties the output register.
// A stalled receiver holds the result in the output register; the next
// pixel is still taken and computed, and waits for the register to free up.
`include "mandelbrot_membership_top_macros.svh"

module mandelbrot_membership_top import mbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        inside_res_o
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SCx   = 4'd1;
  localparam logic [3:0] SCy   = 4'd2;
  localparam logic [3:0] SCi   = 4'd3;
  localparam logic [3:0] SAa   = 4'd4;
  localparam logic [3:0] SBb   = 4'd5;
  localparam logic [3:0] SAb   = 4'd6;
  localparam logic [3:0] SUpd  = 4'd7;
  localparam logic [3:0] SDone = 4'd8;

  cfg_t       cfg_q;
  logic [3:0] state_q, state_d;
  logic       res_q, res_d;
  logic       out_valid_q, inside_q;
  logic       in_xfer, out_free;
  ctrl_t      ctrl;
  status_t    status;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_start  <= 32'shE000_0000;
      cfg_q.x_step   <= 32'sd196608;
      cfg_q.y_start  <= 32'shF000_0000;
      cfg_q.y_step   <= 32'sd131072;
      cfg_q.bailout  <= 32'd268435456;
      cfg_q.max_iter <= 16'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegXStart:  cfg_q.x_start  <= $signed(cfg_wdata_i);
        RegXStep:   cfg_q.x_step   <= $signed(cfg_wdata_i);
        RegYStart:  cfg_q.y_start  <= $signed(cfg_wdata_i);
        RegYStep:   cfg_q.y_step   <= $signed(cfg_wdata_i);
        RegBailout: cfg_q.bailout  <= cfg_wdata_i;
        RegMaxIter: cfg_q.max_iter <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    ctrl.column = column_i;
    ctrl.row    = row_i;
    ctrl.op     = OpIdle;
    case (state_q)
      SIdle: begin
        if (in_xfer) begin
          ctrl.op = OpLoad;
          state_d = SCx;
        end
      end
      SCx: begin
        ctrl.op = OpCx;
        state_d = SCy;
      end
      SCy: begin
        ctrl.op = OpCy;
        state_d = SCi;
      end
      SCi: begin
        ctrl.op = OpCi;
        state_d = SAa;
      end
      SAa: begin
        ctrl.op = OpAa;
        state_d = SBb;
      end
      SBb: begin
        ctrl.op = OpBb;
        state_d = SAb;
      end
      SAb: begin
        ctrl.op = OpAb;
        if (status.escape) begin
          res_d   = 1'b0;
          state_d = SDone;
        end else if (status.last) begin
          res_d   = 1'b1;
          state_d = SDone;
        end else begin
          state_d = SUpd;
        end
      end
      SUpd: begin
        ctrl.op = OpUpd;
        state_d = SAa;
      end
      SDone: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if (state_q == SDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SDone && out_free) begin
      inside_q <= res_q;
    end
  end

  mbm_core u_core (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  assign in_ready_o   = (state_q == SIdle);
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  `MBM_ASSERT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `MBM_ASSERT(a_done_loads_out, clk_i, rst_ni,
              state_q == SDone && out_free |=> out_valid_o && in_ready_o)
  `MBM_ASSERT(a_out_drains, clk_i, rst_ni,
              out_valid_o && out_ready_i && state_q != SDone |=> !out_valid_o)
  `MBM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o && in_ready_o)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for mandelbrot_membership_top: orbit predictor, directed views, random pixels.
module tb_top import mbm_pkg::*; ();

  localparam logic [2:0]         RegSpare6   = 3'd6;
  localparam logic [2:0]         RegSpare7   = 3'd7;
  localparam logic [31:0]        BailoutFour = 32'h1000_0000;
  localparam logic signed [31:0] OneQ428     = 32'sh1000_0000;
  localparam logic signed [31:0] MinQ428     = 32'sh8000_0000;
  localparam logic signed [31:0] MaxQ428     = 32'sh7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = RegXStart;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] pix_column = '0;
  logic [11:0] pix_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        inside_res;

  cfg_t view_cfg;
  logic expected_inside_q[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  mandelbrot_membership_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .column_i    (pix_column),
    .row_i       (pix_row),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .inside_res_o(inside_res)
  );

  always #5 clk = ~clk;

  function automatic longint clip_q4_28(input longint v);
    if (v > longint'(MaxQ428)) return longint'(MaxQ428);
    if (v < longint'(MinQ428)) return longint'(MinQ428);
    return v;
  endfunction

  function automatic logic predict_inside(input cfg_t v, input logic [11:0] col,
                                          input logic [11:0] rw);
    longint      c_re, c_im, a, b, aa, bb, ab;
    logic [63:0] sum, norm;
    c_re = clip_q4_28(longint'(v.x_start) + longint'(col) * longint'(v.x_step));
    c_im = clip_q4_28(longint'(v.y_start) + longint'(rw) * longint'(v.y_step));
    a = 0;
    b = 0;
    for (int k = 0; k <= int'(v.max_iter); k++) begin
      aa = a * a;
      bb = b * b;
      ab = a * b;
      sum = aa + bb;
      norm = sum >> 30;
      if (norm > 64'h0000_0000_FFFF_FFFF) norm = 64'h0000_0000_FFFF_FFFF;
      if (norm >= {32'd0, v.bailout}) return 1'b0;
      a = clip_q4_28(((aa - bb) >>> 28) + c_re);
      b = clip_q4_28((ab >>> 27) + c_im);
    end
    return 1'b1;
  endfunction

  function automatic cfg_t random_view();
    cfg_t   v;
    longint step_x, step_y, mid_x, mid_y;
    if ($urandom_range(4) == 0) begin
      v.x_start = $urandom();
      v.x_step  = $urandom();
      v.y_start = $urandom();
      v.y_step  = $urandom();
      v.bailout = $urandom();
    end else begin
      step_x = longint'($urandom_range(400000)) - 200000;
      step_y = longint'($urandom_range(400000)) - 200000;
      mid_x  = longint'($urandom_range(268435456)) - 335544320;
      mid_y  = longint'($urandom_range(161061273)) - 80530636;
      v.x_start = 32'(mid_x - 2048 * step_x);
      v.x_step  = 32'(step_x);
      v.y_start = 32'(mid_y - 2048 * step_y);
      v.y_step  = 32'(step_y);
      case ($urandom_range(3))
        0:       v.bailout = $urandom();
        1:       v.bailout = $urandom_range(32'h4000_0000);
        default: v.bailout = BailoutFour;
      endcase
    end
    v.max_iter = 16'($urandom_range(48));
    return v;
  endfunction

  task automatic apply_view(input cfg_t v);
    logic [31:0] junk;
    junk = $urandom();
    cfg_we    <= 1'b1;
    cfg_idx   <= RegXStart;
    cfg_wdata <= v.x_start;
    @(posedge clk);
    cfg_idx   <= RegXStep;
    cfg_wdata <= v.x_step;
    @(posedge clk);
    cfg_idx   <= RegYStart;
    cfg_wdata <= v.y_start;
    @(posedge clk);
    cfg_idx   <= RegYStep;
    cfg_wdata <= v.y_step;
    @(posedge clk);
    cfg_idx   <= RegBailout;
    cfg_wdata <= v.bailout;
    @(posedge clk);
    cfg_idx   <= RegMaxIter;
    cfg_wdata <= {junk[31:16], v.max_iter};
    @(posedge clk);
    // unmapped index, must leave the view untouched
    cfg_idx   <= junk[0] ? RegSpare6 : RegSpare7;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we    <= 1'b0;
    view_cfg = v;
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] rw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pix_column <= col;
    pix_row    <= rw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_inside_q.push_back(predict_inside(view_cfg, col, rw));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_inside_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
  endtask

  task automatic test_iteration_limits();
    cfg_t v;
    settle();
    v = view_cfg;
    v.max_iter = '0;
    v.bailout  = BailoutFour;
    apply_view(v);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    settle();
    v.bailout = '0;
    apply_view(v);
    send_pixel(12'd17, 12'd4000);
    send_pixel(12'd4095, 12'd0);
    settle();
    // origin (column 0) stays bounded for the full 16-bit limit; column 3 gives c = 3, which escapes
    v.x_start  = '0;
    v.x_step   = OneQ428;
    v.y_start  = '0;
    v.y_step   = '0;
    v.bailout  = BailoutFour;
    v.max_iter = 16'hFFFF;
    apply_view(v);
    send_pixel(12'd3, 12'd7);
    send_pixel(12'd0, 12'd4095);
  endtask

  task automatic test_saturated_view();
    cfg_t v;
    settle();
    v.x_start  = MinQ428;
    v.x_step   = MinQ428;
    v.y_start  = MaxQ428;
    v.y_step   = MaxQ428;
    v.bailout  = 32'hFFFF_FFFF;
    v.max_iter = 16'd3;
    apply_view(v);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1, 12'd2);
  endtask

  task automatic test_random_pixels(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int blk = 0; blk < 5; blk++) begin
      settle();
      apply_view(random_view());
      for (int n = 0; n < 50; n++) begin
        send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_inside_q.size() == 0) begin
        $display("%0t: inside_res expected none actual %0b", $time, inside_res);
        mismatches++;
      end else begin
        if (inside_res !== expected_inside_q[0]) begin
          $display("%0t: inside_res expected %0b actual %0b", $time,
                   expected_inside_q[0], inside_res);
          mismatches++;
        end
        void'(expected_inside_q.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    view_cfg.x_start  = -32'sd536870912;
    view_cfg.x_step   = 32'sd196608;
    view_cfg.y_start  = -32'sd268435456;
    view_cfg.y_step   = 32'sd131072;
    view_cfg.bailout  = BailoutFour;
    view_cfg.max_iter = 16'd255;
    send_idle_pct = 36;
    recv_idle_pct = 61;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_iteration_limits();
    test_saturated_view();
    test_random_pixels(36, 61);
    test_random_pixels(61, 36);
    test_random_pixels(0, 0);
    settle();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && expected_inside_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("tb: failure");
    $finish;
  end

endmodule
